### rtl/core/sia_pkg.sv
// ---------------------------------------------------------------------------
// Signed integer ALU package
// Shared types, action codes and error codes for the integer unit.
// ---------------------------------------------------------------------------
package sia_pkg;

  localparam int unsigned WIDTH   = 64;
  localparam int unsigned CNT_W   = $clog2(WIDTH + 2);
  // A load followed by WIDTH divider steps.
  localparam int unsigned DIV_END = WIDTH + 1;

  typedef enum logic [4:0] {
    ACT_ADD = 5'd0, ACT_SUB = 5'd1, ACT_MUL = 5'd2, ACT_DIV = 5'd3,
    ACT_REM = 5'd4, ACT_ABS = 5'd5, ACT_NEG = 5'd6, ACT_AND = 5'd7,
    ACT_OR = 5'd8, ACT_XOR = 5'd9, ACT_SHL = 5'd10, ACT_SHR = 5'd11,
    ACT_NOT = 5'd12, ACT_INC = 5'd13, ACT_DEC = 5'd14, ACT_EQ = 5'd15,
    ACT_NE = 5'd16, ACT_GT = 5'd17, ACT_GE = 5'd18, ACT_LT = 5'd19,
    ACT_LE = 5'd20, ACT_POS = 5'd21, ACT_BITS = 5'd22, ACT_DIGITS = 5'd23
  } action_t;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_ZERO_DIV = 2'd1;
  localparam logic [1:0] ERR_BAD_BASE = 2'd2;

  typedef struct packed {
    logic [4:0]         action;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] result;
    logic [1:0]         error_code;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_DIV, ST_LOOP, ST_DONE
  } state_t;

  // Control from the sequencer to the divider.
  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

endpackage

### rtl/core/sia_divider.sv
// ---------------------------------------------------------------------------
// Radix-2 divider
// Unsigned restoring divider; one quotient bit per step.
// ---------------------------------------------------------------------------
module sia_divider
  import sia_pkg::*;
(
  input  logic             clk,
  input  div_ctrl_t        ctrl,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder
);

  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] dsr;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   shifted;

  assign shifted = {rem, quo[WIDTH-1]};
  assign trial   = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (ctrl.step) begin
      if (!trial[WIDTH]) begin
        rem <= trial[WIDTH-1:0];
        quo <= {quo[WIDTH-2:0], 1'b1};
      end else begin
        rem <= shifted[WIDTH-1:0];
        quo <= {quo[WIDTH-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

### rtl/core/signed_integer_alu_core.sv
// ---------------------------------------------------------------------------
// Signed integer ALU core
// 64-bit signed integer unit with a shared radix-2 divider.
// ---------------------------------------------------------------------------
// From the accepted start to done: simple actions and error cases go straight
// to the done state, mul forms four 32x32 partial products, one per cycle,
// div and rem take a load and 64 divider steps, and digit count takes a load
// and 64 divider steps per digit, at most 64 digits. busy stays high
// until the done beat, so one item runs at a time and the next one can be
// accepted at the edge that ends the done beat. Synchronous reset returns
// the sequencer to idle and clears done; the receiver cannot stall.
module signed_integer_alu_core
  import sia_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_item_t  operation,
  output logic      busy,
  output logic      done,
  output out_item_t response
);

  state_t state, state_next;
  logic [4:0]       act;
  logic [WIDTH-1:0] a, b, mag_a, mag_b, acc, m;
  logic [CNT_W-1:0] cnt, ndig;
  logic [1:0]       part;
  div_ctrl_t        dctl;
  logic [WIDTH-1:0] quotient, remainder, div_src;
  logic [WIDTH-1:0] simple_res;
  logic [1:0]       simple_err;
  logic [WIDTH-1:0] result;
  logic [1:0]       err;
  logic             a_neg, b_neg, slt_ab, slt_ba;
  logic [5:0]       amt;
  logic [31:0]      pa, pb;
  logic [63:0]      prod;
  logic [CNT_W-1:0] nbits;

  assign a_neg  = a[WIDTH-1];
  assign b_neg  = b[WIDTH-1];
  assign mag_a  = a_neg ? -a : a;
  assign mag_b  = b_neg ? -b : b;
  assign slt_ab = $signed(a) < $signed(b);
  assign slt_ba = $signed(b) < $signed(a);
  assign amt    = b[5:0];

  always_comb begin
    nbits = '0;
    for (int i = 0; i < WIDTH; i++) begin
      if (mag_a[i]) nbits = CNT_W'(i + 1);
    end
  end

  always_comb begin
    simple_res = '0;
    simple_err = ERR_NONE;
    case (act)
      ACT_ADD: simple_res = a + b;
      ACT_SUB: simple_res = a - b;
      ACT_ABS: simple_res = mag_a;
      ACT_NEG: simple_res = -a;
      ACT_AND: simple_res = a & b;
      ACT_OR:  simple_res = a | b;
      ACT_XOR: simple_res = a ^ b;
      ACT_SHL: simple_res = (32'(amt) >= WIDTH) ? '0 : a << amt;
      ACT_SHR: simple_res = (32'(amt) >= WIDTH) ? {WIDTH{a_neg}} :
                            WIDTH'($signed(a) >>> amt);
      ACT_NOT: simple_res = ~a;
      ACT_INC: simple_res = a + WIDTH'(1);
      ACT_DEC: simple_res = a - WIDTH'(1);
      ACT_EQ:  simple_res = WIDTH'(a == b);
      ACT_NE:  simple_res = WIDTH'(a != b);
      ACT_GT:  simple_res = WIDTH'(slt_ba);
      ACT_GE:  simple_res = WIDTH'(!slt_ab);
      ACT_LT:  simple_res = WIDTH'(slt_ab);
      ACT_LE:  simple_res = WIDTH'(!slt_ba);
      ACT_POS: simple_res = WIDTH'(!a_neg && (a != '0));
      ACT_BITS: simple_res = WIDTH'(nbits);
      default: simple_res = '0;
    endcase
  end

  // Partial product: part[1] picks the half of a, part[0] the half of b.
  assign pa   = part[1] ? 32'(64'(a) >> 32) : 32'(64'(a));
  assign pb   = part[0] ? 32'(64'(b) >> 32) : 32'(64'(b));
  assign prod = 64'(pa) * 64'(pb);

  // The first digit divides |a|; later digits divide the previous quotient.
  assign div_src = (state == ST_LOOP && ndig != '0) ? m : mag_a;

  sia_divider u_div (
    .clk(clk), .ctrl(dctl), .dividend(div_src), .divisor(mag_b),
    .quotient(quotient), .remainder(remainder)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) begin
        if (operation.action == ACT_MUL) state_next = ST_MUL;
        else if (operation.action == ACT_DIV || operation.action == ACT_REM)
          state_next = (operation.operand_b[WIDTH-1:0] == '0) ? ST_DONE : ST_DIV;
        else if (operation.action == ACT_DIGITS)
          state_next = ($signed(operation.operand_b[WIDTH-1:0]) < 2) ? ST_DONE : ST_LOOP;
        else state_next = ST_DONE;
      end
      ST_MUL:  if (cnt == CNT_W'(4)) state_next = ST_DONE;
      ST_DIV:  if (cnt == CNT_W'(DIV_END)) state_next = ST_DONE;
      ST_LOOP: if (cnt == CNT_W'(DIV_END) && quotient == '0) state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    dctl.load = 1'b0;
    dctl.step = 1'b0;
    case (state)
      ST_DIV, ST_LOOP: begin
        dctl.load = (cnt == '0);
        dctl.step = (cnt != '0) && (cnt != CNT_W'(DIV_END));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_DONE);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (start) begin
        act  <= operation.action;
        a    <= operation.operand_a[WIDTH-1:0];
        b    <= operation.operand_b[WIDTH-1:0];
        cnt  <= '0;
        part <= '0;
        acc  <= '0;
        ndig <= '0;
      end
      ST_MUL: if (cnt != CNT_W'(4)) begin
        // Only the parts whose shift stays below 64 bits contribute.
        case (part)
          2'd0: acc <= acc + WIDTH'(prod);
          2'd1, 2'd2: acc <= acc + WIDTH'(prod << 32);
          default: ;
        endcase
        part <= part + 2'd1;
        cnt  <= cnt + CNT_W'(1);
      end
      ST_DIV: if (cnt != CNT_W'(DIV_END)) cnt <= cnt + CNT_W'(1);
      ST_LOOP: begin
        if (cnt == CNT_W'(DIV_END)) begin
          m    <= quotient;
          ndig <= ndig + CNT_W'(1);
          cnt  <= '0;
        end else begin
          cnt <= cnt + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    err    = ERR_NONE;
    result = simple_res;
    case (act)
      ACT_MUL: result = acc;
      ACT_DIV: begin
        if (b == '0) err = ERR_ZERO_DIV;
        result = (a_neg != b_neg) ? -quotient : quotient;
      end
      ACT_REM: begin
        if (b == '0) err = ERR_ZERO_DIV;
        result = (a_neg && remainder != '0) ? (-remainder + b) : remainder;
      end
      ACT_DIGITS: begin
        if ($signed(b) < 2) err = ERR_BAD_BASE;
        result = (mag_a == '0) ? WIDTH'(1) : WIDTH'(ndig);
      end
      default: err = simple_err;
    endcase
    if (err != ERR_NONE) result = '0;
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE) begin
      response.result     <= 64'($signed(result));
      response.error_code <= err;
    end
  end

  assign busy = (state != ST_IDLE);

  a_done_after_done_state: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |=> done) else $error("done missing");
  a_busy_no_done: assert property (@(posedge clk) disable iff (rst)
    done |-> !$past(start && !busy)) else $error("done too early");
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");

endmodule

### tb/sv/signed_integer_alu_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Signed integer ALU core testbench
// A directed set of corner cases is followed by random operations. The
// operations are sent in bursts with random gaps between them. Each result
// is checked against an internal prediction of the action.
// ---------------------------------------------------------------------------
module signed_integer_alu_core_tb;
  import sia_pkg::*;

  localparam int unsigned RANDOM_OPS = 1800;
  localparam int unsigned DRAIN_AT   = 600;
  localparam longint unsigned CYCLE_LIMIT = 40000000;
  localparam logic [63:0] MIN_VAL = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_VAL = 64'h7fff_ffff_ffff_ffff;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  in_item_t  operation = '0;
  logic      busy;
  logic      done;
  out_item_t response;

  in_item_t  pending_ops[$];
  out_item_t expected_results[$];
  int unsigned mismatches = 0;
  int unsigned sent_count = 0;
  longint unsigned cycle_count = 0;

  signed_integer_alu_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .operation(operation),
    .busy     (busy),
    .done     (done),
    .response (response)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] mag64(logic [63:0] x);
    return x[63] ? 64'd0 - x : x;
  endfunction

  function automatic out_item_t alu_predict(in_item_t op);
    out_item_t   res;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] m;
    logic [63:0] q;
    logic [5:0]  amt;
    int unsigned n;
    a = op.operand_a;
    b = op.operand_b;
    amt = b[5:0];
    res.result = '0;
    res.error_code = ERR_NONE;
    case (action_t'(op.action))
      ACT_ADD: res.result = a + b;
      ACT_SUB: res.result = a - b;
      ACT_MUL: res.result = a * b;
      ACT_DIV: begin
        if (b == 0) res.error_code = ERR_ZERO_DIV;
        else begin
          q = mag64(a) / mag64(b);
          res.result = (a[63] != b[63]) ? 64'd0 - q : q;
        end
      end
      ACT_REM: begin
        if (b == 0) res.error_code = ERR_ZERO_DIV;
        else begin
          q = mag64(a) % mag64(b);
          // A negative remainder gets the divisor added, whatever its sign.
          res.result = (a[63] && q != 0) ? (64'd0 - q) + b : q;
        end
      end
      ACT_ABS: res.result = mag64(a);
      ACT_NEG: res.result = 64'd0 - a;
      ACT_AND: res.result = a & b;
      ACT_OR:  res.result = a | b;
      ACT_XOR: res.result = a ^ b;
      ACT_SHL: res.result = a << amt;
      ACT_SHR: res.result = $signed(a) >>> amt;
      ACT_NOT: res.result = ~a;
      ACT_INC: res.result = a + 64'd1;
      ACT_DEC: res.result = a - 64'd1;
      ACT_EQ:  res.result = 64'(a == b);
      ACT_NE:  res.result = 64'(a != b);
      ACT_GT:  res.result = 64'($signed(a) > $signed(b));
      ACT_GE:  res.result = 64'($signed(a) >= $signed(b));
      ACT_LT:  res.result = 64'($signed(a) < $signed(b));
      ACT_LE:  res.result = 64'($signed(a) <= $signed(b));
      ACT_POS: res.result = 64'($signed(a) > 0);
      ACT_BITS: begin
        m = mag64(a);
        n = 0;
        while (m != 0) begin
          n++;
          m = m >> 1;
        end
        res.result = 64'(n);
      end
      ACT_DIGITS: begin
        if ($signed(b) < 2) res.error_code = ERR_BAD_BASE;
        else begin
          m = mag64(a);
          n = (m == 0) ? 1 : 0;
          while (m != 0) begin
            n++;
            m = m / b;
          end
          res.result = 64'(n);
        end
      end
      default: res.result = '0;
    endcase
    return res;
  endfunction

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    case ($urandom_range(0, 9))
      0: v = MIN_VAL;
      1: v = MAX_VAL;
      2: v = -64'($urandom_range(0, 3));
      3: v = 64'($urandom_range(0, 3));
      4, 5: v = 64'($signed(32'($urandom_range(0, 2000) - 1000)));
      6: v = {{32{1'b0}}, $urandom};
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic in_item_t rand_op();
    in_item_t op;
    op.action = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(24, 31))
                                              : 5'($urandom_range(0, 23));
    op.operand_a = rand_operand();
    op.operand_b = rand_operand();
    if (action_t'(op.action) == ACT_DIGITS) begin
      // Keep base two rare, since each digit costs a full divide.
      case ($urandom_range(0, 19))
        0: op.operand_b = 64'd2;
        1, 2: op.operand_b = rand_operand();
        3, 4: op.operand_b = {$urandom, $urandom};
        default: op.operand_b = 64'($urandom_range(3, 1000));
      endcase
    end
    return op;
  endfunction

  function automatic in_item_t mk(action_t act, logic [63:0] a, logic [63:0] b);
    in_item_t op;
    op.action = act;
    op.operand_a = a;
    op.operand_b = b;
    return op;
  endfunction

  // Driver: bursts of beats separated by random gaps.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(alu_predict(operation));
        void'(pending_ops.pop_front());
        sent_count++;
        if (burst_left > 0) burst_left--;
      end
      if (burst_left == 0 && gap_left == 0) begin
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
        burst_left = $urandom_range(1, 12);
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_ops.size() == 0 ||
                   (sent_count == DRAIN_AT && expected_results.size() != 0)) begin
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        operation <= pending_ops[0];
      end
    end
  end

  // Monitor: every done beat is checked against the oldest prediction.
  always @(posedge clk) begin
    out_item_t exp_res;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result %h err %0d", response.result,
                   response.error_code);
      end else begin
        exp_res = expected_results.pop_front();
        if (response.result !== exp_res.result ||
            response.error_code !== exp_res.error_code) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %h err %0d, expected %h err %0d",
                     response.result, response.error_code,
                     exp_res.result, exp_res.error_code);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    in_item_t op;
    // Extremes and special cases first.
    pending_ops.push_back(mk(ACT_ADD, MAX_VAL, 64'd1));
    pending_ops.push_back(mk(ACT_SUB, MIN_VAL, 64'd1));
    pending_ops.push_back(mk(ACT_MUL, MAX_VAL, MAX_VAL));
    pending_ops.push_back(mk(ACT_DIV, 64'd7, 64'd0));
    pending_ops.push_back(mk(ACT_REM, -64'd7, 64'd0));
    pending_ops.push_back(mk(ACT_DIV, MIN_VAL, -64'd1));
    pending_ops.push_back(mk(ACT_REM, MIN_VAL, -64'd1));
    pending_ops.push_back(mk(ACT_REM, -64'd7, -64'd2));
    pending_ops.push_back(mk(ACT_DIV, -64'd7, 64'd2));
    pending_ops.push_back(mk(ACT_ABS, MIN_VAL, 64'd0));
    pending_ops.push_back(mk(ACT_NEG, MIN_VAL, 64'd0));
    pending_ops.push_back(mk(ACT_SHL, -64'd1, 64'd63));
    pending_ops.push_back(mk(ACT_SHR, MIN_VAL, 64'hffff_ffff_ffff_ffff));
    pending_ops.push_back(mk(ACT_BITS, MIN_VAL, 64'd0));
    pending_ops.push_back(mk(ACT_BITS, 64'd0, 64'd0));
    pending_ops.push_back(mk(ACT_DIGITS, 64'd0, 64'd10));
    pending_ops.push_back(mk(ACT_DIGITS, 64'd5, 64'd1));
    pending_ops.push_back(mk(ACT_DIGITS, 64'd5, MIN_VAL));
    pending_ops.push_back(mk(ACT_DIGITS, -64'd5, MAX_VAL));
    pending_ops.push_back(mk(ACT_DIGITS, MIN_VAL, 64'd2));
    pending_ops.push_back(mk(ACT_POS, MIN_VAL, 64'd0));
    pending_ops.push_back(mk(ACT_GE, MIN_VAL, MAX_VAL));
    pending_ops.push_back(mk(action_t'(5'd31), MAX_VAL, MAX_VAL));
    for (int k = 0; k < 24; k++)
      pending_ops.push_back(mk(action_t'(k), -64'd3, 64'd5));
    for (int k = 0; k < RANDOM_OPS; k++) begin
      op = rand_op();
      pending_ops.push_back(op);
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    while (pending_ops.size() != 0 || expected_results.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
